// File: rtl/rov_pkg.sv
// Shared constants, types and the quarter-wave sine table for the rectangle overlap test.
// No dependencies; used by every module in rtl/.
package rov_pkg;

   localparam int ANGLE_BITS     = 12;
   localparam int SINE_FRAC_BITS = 15;
   localparam int NUM_STAGES     = 8;
   localparam int NUM_AXES       = 4;

   localparam int QUARTER  = 1 << (ANGLE_BITS - 2);
   localparam int IDX_W    = ANGLE_BITS - 1;
   localparam int MAG_W    = SINE_FRAC_BITS + 1;
   localparam int SIN_W    = SINE_FRAC_BITS + 2;
   localparam int CTR_W    = 24;
   localparam int SZ_W     = 16;
   localparam int D_W      = CTR_W + 2;
   localparam int GPROD_W  = D_W + SIN_W;
   localparam int GSUM_W   = GPROD_W + 1;
   localparam int GAP_W    = D_W + SINE_FRAC_BITS + 1;
   localparam int TERM_W   = 2 * SIN_W;
   localparam int DOT_W    = TERM_W + 1;
   localparam int PMAG_W   = 2 * SINE_FRAC_BITS + 2;
   localparam int WP_W     = SZ_W + PMAG_W;
   localparam int REACH_W  = WP_W + 2;
   localparam int NEED_W   = REACH_W - SINE_FRAC_BITS;
   localparam int CMP_W    = (GAP_W > NEED_W) ? GAP_W : NEED_W;

   typedef logic [MAG_W-1:0]          sine_mag_type;
   typedef sine_mag_type              sine_table_type [QUARTER+1];
   typedef logic signed [SIN_W-1:0]   sin_type;
   typedef logic signed [D_W-1:0]     delta_type;
   typedef logic [SZ_W-1:0]           size_type;

   typedef struct packed {
      logic [NUM_STAGES:1] en;
   } pipe_ctrl_type;

   // shift-subtract quotient, evaluated only while building the table
   function automatic longint unsigned table_quot(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type    tbl;
      longint unsigned   x;
      longint unsigned   t;
      longint            s;
      longint            v;
      longint            one;
      for (int k = 0; k <= QUARTER; k++) begin
         x = (64'd1686629713 * longint'(k)) >> (ANGLE_BITS - 2);
         t = x;
         s = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = table_quot(t, longint'((2 * n) * (2 * n + 1)));
            if (n[0]) s = s - longint'(t);
            else s = s + longint'(t);
         end
         if (s < 0) s = 0;
         one = longint'(1) << SINE_FRAC_BITS;
         v = (s + (longint'(1) << (29 - SINE_FRAC_BITS))) >>> (30 - SINE_FRAC_BITS);
         if (v > one) v = one;
         tbl[k] = v[MAG_W-1:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

// File: rtl/rov_trig.sv
// Sine/cosine of both rectangle angles: table read (stage 1), sign applied (stage 2).
// Depends on rov_pkg.
module rov_trig (
   input  logic                              clock,
   input  rov_pkg::pipe_ctrl_type            ctrl,
   input  logic [rov_pkg::ANGLE_BITS-1:0]    a_angle,
   input  logic [rov_pkg::ANGLE_BITS-1:0]    b_angle,
   output rov_pkg::sin_type                  sa,
   output rov_pkg::sin_type                  ca,
   output rov_pkg::sin_type                  sb,
   output rov_pkg::sin_type                  cb
);
   import rov_pkg::*;

   logic [ANGLE_BITS-1:0] ang [NUM_AXES];
   logic [IDX_W-1:0]      idx [NUM_AXES];
   sine_mag_type          mag_ff [NUM_AXES];
   logic                  neg_ff [NUM_AXES];
   logic                  neg_in [NUM_AXES];
   sin_type               val_ff [NUM_AXES];

   // order: sin A, cos A, sin B, cos B
   always_comb begin
      ang[0] = a_angle;
      ang[1] = a_angle + ANGLE_BITS'(QUARTER);
      ang[2] = b_angle;
      ang[3] = b_angle + ANGLE_BITS'(QUARTER);
      for (int i = 0; i < NUM_AXES; i++) begin
         neg_in[i] = ang[i][ANGLE_BITS-1];
         if (ang[i][ANGLE_BITS-2])
            idx[i] = IDX_W'(QUARTER) - {1'b0, ang[i][ANGLE_BITS-3:0]};
         else
            idx[i] = {1'b0, ang[i][ANGLE_BITS-3:0]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (ctrl.en[1]) begin
            mag_ff[i] <= SINE_TABLE[idx[i]];
            neg_ff[i] <= neg_in[i];
         end
         if (ctrl.en[2])
            val_ff[i] <= neg_ff[i] ? -$signed({1'b0, mag_ff[i]}) : $signed({1'b0, mag_ff[i]});
      end
   end

   assign sa = val_ff[0];
   assign ca = val_ff[1];
   assign sb = val_ff[2];
   assign cb = val_ff[3];

endmodule

// File: rtl/rov_axis.sv
// Separation test of both rectangles on one unit axis, stages 3 to 7.
// Depends on rov_pkg.
module rov_axis (
   input  logic                     clock,
   input  rov_pkg::pipe_ctrl_type   ctrl,
   input  rov_pkg::delta_type       dx,
   input  rov_pkg::delta_type       dy,
   input  rov_pkg::sin_type         ux,
   input  rov_pkg::sin_type         uy,
   input  rov_pkg::sin_type         sa,
   input  rov_pkg::sin_type         ca,
   input  rov_pkg::sin_type         sb,
   input  rov_pkg::sin_type         cb,
   input  rov_pkg::size_type        wa,
   input  rov_pkg::size_type        ha,
   input  rov_pkg::size_type        wb,
   input  rov_pkg::size_type        hb,
   output logic                     sep
);
   import rov_pkg::*;

   // stage 3: products
   logic signed [GPROD_W-1:0] gx_ff, gy_ff;
   logic signed [TERM_W-1:0]  t_ff [8];
   // stage 4: dot products and magnitudes
   logic signed [GSUM_W-1:0]  gsum;
   logic signed [DOT_W-1:0]   dot [4];
   logic [GSUM_W-1:0]         gabs;
   logic [DOT_W-1:0]          dabs [4];
   logic [GAP_W-1:0]          gap4_ff, gap5_ff, gap6_ff;
   logic [PMAG_W-1:0]         pm_ff [4];
   // stage 5: size products
   logic [WP_W-1:0]           wp_ff [4];
   // stage 6: reach
   logic [REACH_W-1:0]        reach_ff;
   logic [REACH_W-1:0]        reach_up;
   logic [NEED_W-1:0]         need;
   logic                      sep_ff;

   always_comb begin
      gsum = GSUM_W'(gx_ff) + GSUM_W'(gy_ff);
      gabs = gsum[GSUM_W-1] ? GSUM_W'(-gsum) : GSUM_W'(gsum);
      // box A x/y, box B x/y projected on the axis
      dot[0] = DOT_W'(t_ff[0]) + DOT_W'(t_ff[1]);
      dot[1] = DOT_W'(t_ff[2]) - DOT_W'(t_ff[3]);
      dot[2] = DOT_W'(t_ff[4]) + DOT_W'(t_ff[5]);
      dot[3] = DOT_W'(t_ff[6]) - DOT_W'(t_ff[7]);
      for (int i = 0; i < 4; i++)
         dabs[i] = dot[i][DOT_W-1] ? DOT_W'(-dot[i]) : DOT_W'(dot[i]);
      reach_up = reach_ff + REACH_W'((1 << SINE_FRAC_BITS) - 1);
      need     = reach_up[REACH_W-1:SINE_FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         gx_ff   <= dx * ux;
         gy_ff   <= dy * uy;
         t_ff[0] <= ca * ux;
         t_ff[1] <= sa * uy;
         t_ff[2] <= ca * uy;
         t_ff[3] <= sa * ux;
         t_ff[4] <= cb * ux;
         t_ff[5] <= sb * uy;
         t_ff[6] <= cb * uy;
         t_ff[7] <= sb * ux;
      end
      if (ctrl.en[4]) begin
         gap4_ff <= gabs[GAP_W-1:0];
         for (int i = 0; i < 4; i++)
            pm_ff[i] <= dabs[i][PMAG_W-1:0];
      end
      if (ctrl.en[5]) begin
         gap5_ff  <= gap4_ff;
         wp_ff[0] <= wa * pm_ff[0];
         wp_ff[1] <= ha * pm_ff[1];
         wp_ff[2] <= wb * pm_ff[2];
         wp_ff[3] <= hb * pm_ff[3];
      end
      if (ctrl.en[6]) begin
         gap6_ff  <= gap5_ff;
         reach_ff <= REACH_W'(wp_ff[0]) + REACH_W'(wp_ff[1]) +
                     REACH_W'(wp_ff[2]) + REACH_W'(wp_ff[3]);
      end
      if (ctrl.en[7])
         sep_ff <= CMP_W'(gap6_ff) >= CMP_W'(need);
   end

   assign sep = sep_ff;

endmodule

// File: rtl/oriented_rectangle_overlap_test.sv
// Oriented rectangle overlap test, separating-axis scheme on both boxes' face normals.
// Depends on rov_pkg, rov_trig, rov_axis.
// Pipelined from input transfer to result valid; throughput one pair per cycle while rsp_ready is held high.
// Each stage holds while the next is full and stalled; bubbles are squeezed out.
// Synchronous active-high reset clears all stage valid bits; no other state.
module oriented_rectangle_overlap_test (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rov_pkg::CTR_W-1:0]     req_a_center_x,
   input  logic signed [rov_pkg::CTR_W-1:0]     req_a_center_y,
   input  logic [rov_pkg::SZ_W-1:0]             req_a_width,
   input  logic [rov_pkg::SZ_W-1:0]             req_a_height,
   input  logic [rov_pkg::ANGLE_BITS-1:0]       req_a_angle,
   input  logic signed [rov_pkg::CTR_W-1:0]     req_b_center_x,
   input  logic signed [rov_pkg::CTR_W-1:0]     req_b_center_y,
   input  logic [rov_pkg::SZ_W-1:0]             req_b_width,
   input  logic [rov_pkg::SZ_W-1:0]             req_b_height,
   input  logic [rov_pkg::ANGLE_BITS-1:0]       req_b_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_colliding
);
   import rov_pkg::*;

   logic [NUM_STAGES:1]   valid_ff;
   logic [NUM_STAGES:1]   valid_in;
   logic [NUM_STAGES+1:1] en;
   pipe_ctrl_type         ctrl;

   delta_type dx_in, dy_in;
   delta_type dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   size_type  sz1_ff [4], sz2_ff [4], sz3_ff [4], sz4_ff [4];
   sin_type   sa, ca, sb, cb;
   sin_type   ux [NUM_AXES];
   sin_type   uy [NUM_AXES];
   logic [NUM_AXES-1:0] sep;
   logic      colliding_ff;

   always_comb begin
      en[NUM_STAGES+1] = rsp_ready;
      for (int k = NUM_STAGES; k >= 1; k--)
         en[k] = !valid_ff[k] || en[k+1];
      ctrl.en     = en[NUM_STAGES:1];
      valid_in[1] = req_valid;
      for (int k = 2; k <= NUM_STAGES; k++)
         valid_in[k] = valid_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++)
            if (en[k]) valid_ff[k] <= valid_in[k];
      end
   end

   // difference kept one bit wider than the centers, then doubled
   assign dx_in = {(D_W-1)'(req_b_center_x) - (D_W-1)'(req_a_center_x), 1'b0};
   assign dy_in = {(D_W-1)'(req_b_center_y) - (D_W-1)'(req_a_center_y), 1'b0};

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dx1_ff    <= dx_in;
         dy1_ff    <= dy_in;
         sz1_ff[0] <= req_a_width;
         sz1_ff[1] <= req_a_height;
         sz1_ff[2] <= req_b_width;
         sz1_ff[3] <= req_b_height;
      end
      if (en[2]) begin
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         sz2_ff <= sz1_ff;
      end
      if (en[3]) sz3_ff <= sz2_ff;
      if (en[4]) sz4_ff <= sz3_ff;
      if (en[8]) colliding_ff <= ~|sep;
   end

   rov_trig u_trig (
      .clock   (clock),
      .ctrl    (ctrl),
      .a_angle (req_a_angle),
      .b_angle (req_b_angle),
      .sa      (sa),
      .ca      (ca),
      .sb      (sb),
      .cb      (cb)
   );

   always_comb begin
      ux[0] = ca;  uy[0] = sa;
      ux[1] = -sa; uy[1] = ca;
      ux[2] = cb;  uy[2] = sb;
      ux[3] = -sb; uy[3] = cb;
   end

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
      rov_axis u_axis (
         .clock (clock),
         .ctrl  (ctrl),
         .dx    (dx2_ff),
         .dy    (dy2_ff),
         .ux    (ux[i]),
         .uy    (uy[i]),
         .sa    (sa),
         .ca    (ca),
         .sb    (sb),
         .cb    (cb),
         .wa    (sz4_ff[0]),
         .ha    (sz4_ff[1]),
         .wb    (sz4_ff[2]),
         .hb    (sz4_ff[3]),
         .sep   (sep[i])
      );
   end

   assign req_ready     = en[1];
   assign rsp_valid     = valid_ff[NUM_STAGES];
   assign rsp_colliding = colliding_ff;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for oriented_rectangle_overlap_test, depends on rov_pkg: directed and random rectangle
// pairs with random valid/ready idling, checked by given results or a separating-axis predictor.
module tb_top;
   import rov_pkg::*;

   localparam int N_RANDOM  = 1640;
   localparam int QUIET_AT  = 1450;
   localparam int WD_LIMIT  = 4000;

   typedef struct {
      logic signed [CTR_W-1:0]      acx, acy, bcx, bcy;
      logic [SZ_W-1:0]              aw, ah, bw, bh;
      logic [ANGLE_BITS-1:0]        aa, ba;
      int                           hit;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CTR_W-1:0] req_a_center_x = '0, req_a_center_y = '0;
   logic [SZ_W-1:0] req_a_width = '0, req_a_height = '0;
   logic [ANGLE_BITS-1:0] req_a_angle = '0;
   logic signed [CTR_W-1:0] req_b_center_x = '0, req_b_center_y = '0;
   logic [SZ_W-1:0] req_b_width = '0, req_b_height = '0;
   logic [ANGLE_BITS-1:0] req_b_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_colliding;

   longint quarter_tbl [QUARTER+1];
   int     typed_hits [$];
   bit     hit_q [$];
   int     fails = 0;
   int     idle_cycles = 0;
   bit     quiet = 1'b0;

   always #6 clock = ~clock;

   oriented_rectangle_overlap_test u_top (.*);

   initial begin
      longint unsigned x, t;
      longint s, v;
      for (int k = 0; k <= QUARTER; k++) begin
         x = (64'd1686629713 * k) >> (ANGLE_BITS - 2);
         t = x;
         s = x;
         for (int n = 1; n <= 10; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / ((2 * n) * (2 * n + 1));
            s = (n % 2) ? s - longint'(t) : s + longint'(t);
         end
         if (s < 0) s = 0;
         v = (s + (64'sd1 << (29 - SINE_FRAC_BITS))) >>> (30 - SINE_FRAC_BITS);
         quarter_tbl[k] = (v > (64'sd1 << SINE_FRAC_BITS)) ? (64'sd1 << SINE_FRAC_BITS) : v;
      end
   end

   function automatic longint sine_at(int ang);
      int a, quad, r;
      longint v;
      a = ang & ((1 << ANGLE_BITS) - 1);
      quad = (a >> (ANGLE_BITS - 2)) & 3;
      r = a & (QUARTER - 1);
      v = (quad & 1) ? quarter_tbl[QUARTER - r] : quarter_tbl[r];
      return (quad & 2) ? -v : v;
   endfunction

   function automatic longint absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint box_span(longint w, longint h, longint c, longint s,
                                       longint ux, longint uy);
      return w * absval(c * ux + s * uy) + h * absval(-s * ux + c * uy);
   endfunction

   function automatic bit overlap_expected(pair_row_type p);
      longint dx, dy, sa, ca, sb, cb, gap, reach, need;
      longint ux [4], uy [4];
      bit hit;
      dx = 2 * (longint'(p.bcx) - longint'(p.acx));
      dy = 2 * (longint'(p.bcy) - longint'(p.acy));
      sa = sine_at(p.aa);
      ca = sine_at(p.aa + QUARTER);
      sb = sine_at(p.ba);
      cb = sine_at(p.ba + QUARTER);
      ux[0] = ca;  uy[0] = sa;
      ux[1] = -sa; uy[1] = ca;
      ux[2] = cb;  uy[2] = sb;
      ux[3] = -sb; uy[3] = cb;
      hit = 1'b1;
      for (int i = 0; i < 4; i++) begin
         gap = absval(dx * ux[i] + dy * uy[i]);
         reach = box_span(p.aw, p.ah, ca, sa, ux[i], uy[i]) +
                 box_span(p.bw, p.bh, cb, sb, ux[i], uy[i]);
         need = (reach + (64'sd1 << SINE_FRAC_BITS) - 1) >>> SINE_FRAC_BITS;
         if (gap >= need) hit = 1'b0;
      end
      return hit;
   endfunction

   // transfer monitor and checker
   always @(posedge clock) begin
      pair_row_type p;
      int typed;
      bit want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p.acx = req_a_center_x; p.acy = req_a_center_y;
            p.aw = req_a_width; p.ah = req_a_height; p.aa = req_a_angle;
            p.bcx = req_b_center_x; p.bcy = req_b_center_y;
            p.bw = req_b_width; p.bh = req_b_height; p.ba = req_b_angle;
            typed = typed_hits.pop_front();
            hit_q = {hit_q, (typed >= 0 ? bit'(typed) : overlap_expected(p))};
         end
         if (rsp_valid && rsp_ready) begin
            if (hit_q.size() == 0) begin
               $error("colliding: unexpected transfer, actual %0b", rsp_colliding);
               fails++;
            end else begin
               want = hit_q.pop_front();
               if (rsp_colliding !== want) begin
                  $error("colliding: expected %0b actual %0b", want, rsp_colliding);
                  fails++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side stalls
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 40);
         repeat (n) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_pair(pair_row_type p);
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 16);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_center_x <= p.acx; req_a_center_y <= p.acy;
      req_a_width <= p.aw; req_a_height <= p.ah; req_a_angle <= p.aa;
      req_b_center_x <= p.bcx; req_b_center_y <= p.bcy;
      req_b_width <= p.bw; req_b_height <= p.bh; req_b_angle <= p.ba;
      typed_hits = {typed_hits, p.hit};
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
   endtask

   function automatic logic [SZ_W-1:0] rand_size();
      return SZ_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
   endfunction

   function automatic pair_row_type rand_pair();
      pair_row_type p;
      int sel, span;
      sel = $urandom_range(0, 9);
      p.hit = -1;
      p.acx = CTR_W'($urandom); p.acy = CTR_W'($urandom);
      p.aw = rand_size(); p.ah = rand_size();
      p.bw = rand_size(); p.bh = rand_size();
      p.aa = ANGLE_BITS'($urandom); p.ba = ANGLE_BITS'($urandom);
      if (sel < 7) begin
         span = int'(p.aw) + int'(p.ah) + int'(p.bw) + int'(p.bh) + 2;
         p.bcx = p.acx + CTR_W'($urandom_range(0, span) - span / 2);
         p.bcy = p.acy + CTR_W'($urandom_range(0, span) - span / 2);
      end else if (sel < 9) begin
         p.aw = SZ_W'($urandom); p.ah = SZ_W'($urandom);
         p.bw = SZ_W'($urandom); p.bh = SZ_W'($urandom);
         p.bcx = CTR_W'($urandom); p.bcy = CTR_W'($urandom);
      end else begin
         p.bcx = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
         p.acx = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
         p.bcy = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
         p.aw = $urandom_range(0, 1) ? 16'hffff : 16'h0;
         p.bh = $urandom_range(0, 1) ? 16'hffff : 16'h0;
         p.aa = $urandom_range(0, 1) ? 12'hfff : 12'h0;
      end
      return p;
   endfunction

   pair_row_type directed [] = '{
      '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'd16, 16'd16, 16'd16, 16'd16, 12'd0, 12'd0, 1},
      '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0, 0},
      '{24'sd0, 24'sd0, 24'sd32, 24'sd0, 16'd32, 16'd32, 16'd32, 16'd32, 12'd0, 12'd0, 0},
      '{24'sd0, 24'sd0, 24'sd31, 24'sd0, 16'd32, 16'd32, 16'd32, 16'd32, 12'd0, 12'd0, 1},
      '{24'sd0, 24'sd0, 24'sd0, 24'sd32, 16'd32, 16'd32, 16'd32, 16'd32, 12'd0, 12'd0, 0},
      '{-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607,
        16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'd0, 12'd0, 0},
      '{24'sd8388607, 24'sd8388607, -24'sd8388608, -24'sd8388608,
        16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 12'hfff, 0},
      '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
        12'hfff, 12'hfff, 1},
      '{24'sd0, 24'sd0, 24'sd40, 24'sd40, 16'd64, 16'd8, 16'd64, 16'd8, 12'd512, 12'd0, -1},
      '{24'sd0, 24'sd0, 24'sd30, 24'sd0, 16'd32, 16'd32, 16'd32, 16'd32, 12'd512, 12'd512, -1},
      '{24'sd0, 24'sd0, 24'sd30, 24'sd0, 16'd32, 16'd32, 16'd32, 16'd32, 12'd1024, 12'd2048, -1},
      '{24'sd0, 24'sd0, 24'sd30, 24'sd10, 16'd64, 16'd0, 16'd64, 16'd0, 12'd3072, 12'd1000, -1},
      '{24'sd100, -24'sd100, 24'sd150, -24'sd50, 16'd100, 16'd20, 16'd30, 16'd90,
        12'd4095, 12'd1, -1},
      '{-24'sd5, 24'sd5, 24'sd5, -24'sd5, 16'd0, 16'd40, 16'd40, 16'd0, 12'd300, 12'd2500, -1}
   };

   initial begin
      pair_row_type p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_pair(directed[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (hit_q.size() != 0 || typed_hits.size() != 0) @(posedge clock);
         end
         if (i == QUIET_AT) quiet = 1'b1;
         p = rand_pair();
         send_pair(p);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (hit_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
